// ===== src/loop_closure_nearest_frame_search_assert.svh =====
// Assertion macros for the loop closure frame search
`ifndef LOOP_CLOSURE_NEAREST_FRAME_SEARCH_ASSERT_SVH
`define LOOP_CLOSURE_NEAREST_FRAME_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

`define LCNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LCNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LCNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LCNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lcnf_pkg.sv =====
package lcnf_pkg;

    localparam int COORD_W        = 24;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int SQ_W           = 2 * COORD_W + 4;
    localparam int ROOT_W         = COORD_W + 2;
    localparam int DIST_W         = 25;
    localparam int SLOT_W         = 12;
    localparam int GAP_W          = 12;
    localparam int EXT_W          = 8;
    localparam int STEP_W         = 16;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int MAX_FRAMES_DEF = 4096;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd4;

    localparam logic [STEP_W-1:0] LOOP_STEP_RST = 16'd10;
    localparam logic [GAP_W-1:0]  MIN_GAP_RST   = 12'd100;
    localparam logic [EXT_W-1:0]  EXTEND_RST    = 8'd5;
    localparam logic [CFG_W-1:0]  RADIUS_RST    = 24'd17920;
    localparam logic [STEP_W-1:0] SPACING_RST   = 16'd512;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
    } in_t;

    typedef struct packed {
        logic                loop_found;
        logic [SLOT_W-1:0]   match_slot;
        logic [DIST_W-1:0]   match_distance;
        logic                store_full;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RSQ,
        ST_CMP,
        ST_SQRT,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== src/lcnf_store.sv =====
module lcnf_store import lcnf_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int AW         = $clog2(MAX_FRAMES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  in_t           wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_valid,
    output logic [AW-1:0] rd_idx,
    output in_t           rd_data
);

    in_t           mem [MAX_FRAMES];
    in_t           rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_idx   = rd_idx_reg;
    assign rd_data  = rd_data_reg;

endmodule

// ===== src/lcnf_dist.sv =====
module lcnf_dist import lcnf_pkg::*; #(
    parameter int AW = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  in_t             cur,
    input  logic            in_valid,
    input  logic [AW-1:0]   in_idx,
    input  in_t             in_data,
    output logic            sq_valid,
    output logic [AW-1:0]   sq_idx,
    output logic [SQ_W-1:0] sq,
    output logic            busy
);

    logic [2:0]                v_reg;
    logic [AW-1:0]             idx1_reg, idx2_reg, idx3_reg;
    logic [DIFF_W-1:0]         dx_reg, dy_reg, dz_reg;
    logic [2*DIFF_W-1:0]       sx_reg, sy_reg, sz_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic signed [DIFF_W:0]    ex, ey, ez;

    function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W:0] d);
        logic signed [DIFF_W:0] n;
        n = -d;
        return d[DIFF_W] ? n[DIFF_W-1:0] : d[DIFF_W-1:0];
    endfunction

    always_comb
    begin
        ex = (DIFF_W+1)'(cur.pos_x) - (DIFF_W+1)'(in_data.pos_x);
        ey = (DIFF_W+1)'(cur.pos_y) - (DIFF_W+1)'(in_data.pos_y);
        ez = (DIFF_W+1)'(cur.pos_z) - (DIFF_W+1)'(in_data.pos_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= abs_d(ex);
        dy_reg   <= abs_d(ey);
        dz_reg   <= abs_d(ez);
        idx1_reg <= in_idx;
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
        sz_reg   <= dz_reg * dz_reg;
        idx2_reg <= idx1_reg;
        sum_reg  <= SQ_W'(sx_reg) + SQ_W'(sy_reg) + SQ_W'(sz_reg);
        idx3_reg <= idx2_reg;
    end

    assign sq_valid = v_reg[2];
    assign sq_idx   = idx3_reg;
    assign sq       = sum_reg;
    assign busy     = |v_reg;

endmodule

// ===== src/lcnf_isqrt.sv =====
module lcnf_isqrt import lcnf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [ROOT_W+2:0]   rem_sh, trial;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial  = (ROOT_W+3)'({root_reg, 2'b01});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= (2*ROOT_W)'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= (ROOT_W+1)'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (ROOT_W+1)'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/lcnf_div.sv =====
module lcnf_div import lcnf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ROOT_W-1:0] dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              done,
    output logic [ROOT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [ROOT_W-1:0] dvd_reg, quo_reg;
    logic [STEP_W-1:0] dsr_reg, rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [STEP_W:0]   rem_sh;

    assign rem_sh = {rem_reg, dvd_reg[ROOT_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ROOT_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_reg <= STEP_W'(rem_sh - {1'b0, dsr_reg});
                quo_reg <= {quo_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= STEP_W'(rem_sh);
                quo_reg <= {quo_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/loop_closure_nearest_frame_search.sv =====
// Loop closure nearest key frame search.
// Input channel (in_valid/in_stall/in_data): one key frame position per item.
// Output channel (out_valid/out_stall/out_data): exactly one result per item.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// A stored frame whose skip counter reaches its target, with at least the
// minimum gap of frames stored before it, triggers a scan over the older
// frames through the position memory, one read a cycle, followed, when a
// candidate is kept, by a bit-serial square root and, when rejected, a
// bit-serial division. The memory read port sets the scan rate. One item is
// in work at a time; the next is taken once the result sits in the output
// register.
// Reset returns the configuration to its defaults and clears frame count and
// skip counter; the skip target starts at the default loop step. The position
// memory needs no clearing as only written slots are read.
// When the receiver stalls, the result holds in the output register; a
// further result waits in its finishing state until that register frees.
module loop_closure_nearest_frame_search import lcnf_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

`include "loop_closure_nearest_frame_search_assert.svh"

    localparam int AW   = $clog2(MAX_FRAMES);
    localparam int FC_W = $clog2(MAX_FRAMES + 1);
    localparam int CW   = ((FC_W > GAP_W) ? FC_W : GAP_W) + 1;
    localparam int XW   = (AW > EXT_W) ? AW : EXT_W;

    state_t state_reg, state_next;

    logic [STEP_W-1:0] loop_step_reg, spacing_reg;
    logic [GAP_W-1:0]  min_gap_reg;
    logic [EXT_W-1:0]  extend_reg;
    logic [CFG_W-1:0]  radius_reg;

    logic [FC_W-1:0]   frame_count_reg, scan_len_reg, issue_reg;
    logic [STEP_W-1:0] skip_counter_reg, skip_target_reg;
    in_t               cur_reg;
    logic              have_reg, reject_reg;
    logic [SQ_W-1:0]   best_sq_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [2*CFG_W-1:0] rr_reg;
    out_t              res_reg, out_reg;
    logic              out_valid_reg;

    logic              accept, full, attempt, rd_en, scan_done;
    logic              sqrt_start, div_start, out_load;
    logic [CW-1:0]     n_ext, mg_ext, len_w;
    logic [STEP_W-1:0] cnt_inc;
    logic              rd_valid, sq_valid, dist_busy, sqrt_done, div_done;
    logic [AW-1:0]     rd_idx, sq_idx;
    in_t               rd_data;
    logic [SQ_W-1:0]   sq;
    logic [ROOT_W-1:0] root, quotient;
    logic [STEP_W-1:0] divisor, tgt;

    assign accept = in_valid && !in_stall;
    assign full   = (frame_count_reg >= FC_W'(MAX_FRAMES));
    assign n_ext  = CW'(frame_count_reg) + CW'(1);
    assign mg_ext = CW'(min_gap_reg);
    assign len_w  = (min_gap_reg <= GAP_W'(1)) ? (n_ext - CW'(1)) : (n_ext - mg_ext + CW'(1));
    assign cnt_inc = (skip_counter_reg == STEP_MAX) ? STEP_MAX : skip_counter_reg + 1'b1;
    assign attempt = (cnt_inc >= skip_target_reg) && (n_ext >= mg_ext + CW'(1));
    assign scan_done = (issue_reg == scan_len_reg) && !rd_valid && !dist_busy;
    assign divisor = (spacing_reg == '0) ? STEP_W'(1) : spacing_reg;

    always_comb
    begin
        if (quotient > ROOT_W'(STEP_MAX))
        begin
            tgt = STEP_MAX;
        end
        else if (quotient[STEP_W-1:0] < loop_step_reg)
        begin
            tgt = loop_step_reg;
        end
        else
        begin
            tgt = quotient[STEP_W-1:0];
        end
    end

    lcnf_store #(.MAX_FRAMES(MAX_FRAMES), .AW(AW)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && !full),
        .wr_addr  (frame_count_reg[AW-1:0]),
        .wr_data  (in_data),
        .rd_en    (rd_en),
        .rd_addr  (issue_reg[AW-1:0]),
        .rd_valid (rd_valid),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data)
    );

    lcnf_dist #(.AW(AW)) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur      (cur_reg),
        .in_valid (rd_valid),
        .in_idx   (rd_idx),
        .in_data  (rd_data),
        .sq_valid (sq_valid),
        .sq_idx   (sq_idx),
        .sq       (sq),
        .busy     (dist_busy)
    );

    lcnf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (best_sq_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    lcnf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (root),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        rd_en      = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = (!full && attempt) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                rd_en = (issue_reg < scan_len_reg);
                if (scan_done)
                begin
                    if (!have_reg || (XW'(best_idx_reg) < XW'(extend_reg)))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_RSQ;
                    end
                end
            end
            ST_RSQ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (reject_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_step_reg    <= LOOP_STEP_RST;
            min_gap_reg      <= MIN_GAP_RST;
            extend_reg       <= EXTEND_RST;
            radius_reg       <= RADIUS_RST;
            spacing_reg      <= SPACING_RST;
            frame_count_reg  <= '0;
            skip_counter_reg <= '0;
            skip_target_reg  <= LOOP_STEP_RST;
            issue_reg        <= '0;
            have_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOP_STEP: loop_step_reg <= cfg_data[STEP_W-1:0];
                    CFG_MIN_GAP:   min_gap_reg   <= cfg_data[GAP_W-1:0];
                    CFG_EXTEND:    extend_reg    <= cfg_data[EXT_W-1:0];
                    CFG_RADIUS:    radius_reg    <= cfg_data;
                    CFG_SPACING:   spacing_reg   <= cfg_data[STEP_W-1:0];
                    default:       ;
                endcase
            end

            if (accept && !full)
            begin
                frame_count_reg  <= frame_count_reg + 1'b1;
                skip_counter_reg <= cnt_inc;
                issue_reg        <= '0;
                have_reg         <= 1'b0;
            end

            if (rd_en)
            begin
                issue_reg <= issue_reg + 1'b1;
            end

            // strict compare keeps the earliest slot on a tie
            if (sq_valid && (!have_reg || sq < best_sq_reg))
            begin
                have_reg <= 1'b1;
            end

            if (state_reg == ST_RSQ)
            begin
                skip_counter_reg <= '0;
            end

            if (state_reg == ST_SQRT && sqrt_done && !reject_reg)
            begin
                skip_target_reg <= loop_step_reg;
            end

            if (state_reg == ST_DIV && div_done)
            begin
                skip_target_reg <= tgt;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= in_data;
            res_reg    <= '0;
            res_reg.store_full <= full;
            scan_len_reg <= FC_W'(len_w);
        end

        if (sq_valid && (!have_reg || sq < best_sq_reg))
        begin
            best_sq_reg  <= sq;
            best_idx_reg <= sq_idx;
        end

        if (state_reg == ST_RSQ)
        begin
            rr_reg <= radius_reg * radius_reg;
        end

        if (state_reg == ST_CMP)
        begin
            reject_reg <= (best_sq_reg > SQ_W'(rr_reg));
        end

        if (state_reg == ST_SQRT && sqrt_done && !reject_reg)
        begin
            res_reg.loop_found     <= 1'b1;
            res_reg.match_slot     <= SLOT_W'(best_idx_reg);
            res_reg.match_distance <= (root > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                                 : DIST_W'(root);
        end

        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LCNF_ASSERT_NEXT(a_busy_after_item, clk, rst_n, accept, in_stall)
    `LCNF_ASSERT_NOW(a_loop_not_full, clk, rst_n, out_valid, !(out_data.loop_found && out_data.store_full))
    `LCNF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, frame_count_reg <= FC_W'(MAX_FRAMES))
    `LCNF_ASSERT_NOW(a_scan_in_range, clk, rst_n, rd_en, issue_reg + 1'b1 < frame_count_reg + 1'b1)

endmodule
